// ----- design/soa_pkg.sv -----
`timescale 1ns / 1ps
// Package for the slab object allocator: sizes, codes and item structs.
// No dependencies; used by every module of the block.
package soa_pkg;

  localparam int MAX_SLABS  = 16;
  localparam int PAGE_BYTES = 4096;
  localparam int SLOTS      = 32;
  localparam int SLAB_IDX_W = $clog2(MAX_SLABS);
  localparam int OBJ_W      = 18;
  localparam int SLAB_W     = 24;
  localparam int SLOT_W     = 5;

  localparam logic [1:0] TAG_UNALLOC = 2'd0;
  localparam logic [1:0] TAG_EMPTY   = 2'd1;
  localparam logic [1:0] TAG_PARTIAL = 2'd2;
  localparam logic [1:0] TAG_FULL    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  localparam logic [1:0] REG_OBJECT_SIZE = 2'd0;
  localparam logic [1:0] REG_ALIGN_LOG2  = 2'd1;
  localparam logic [1:0] REG_REGION_BASE = 2'd2;

  typedef struct packed {
    logic        func;
    logic [31:0] address;
  } soa_in_t;

  typedef struct packed {
    logic [31:0] address_res;
    logic [1:0]  status;
  } soa_out_t;

endpackage

// ----- design/soa_size.sv -----
`timescale 1ns / 1ps
// Rounded object size and slab size from the configuration registers.
// Depends on soa_pkg.
module soa_size import soa_pkg::*; (
  input  logic [16:0]       object_size,
  input  logic [3:0]        align_log2,
  output logic [OBJ_W-1:0]  obj_bytes,
  output logic [SLAB_W-1:0] slab_bytes
);

  localparam logic [OBJ_W-1:0]  FLOOR_SZ  = OBJ_W'(PAGE_BYTES / SLOTS);
  localparam logic [OBJ_W-1:0]  HALF_PAGE = OBJ_W'(PAGE_BYTES / 2);
  localparam logic [OBJ_W-1:0]  PMASK_O   = OBJ_W'(PAGE_BYTES - 1);
  localparam logic [SLAB_W-1:0] PMASK_S   = SLAB_W'(PAGE_BYTES - 1);

  logic [OBJ_W-1:0]  sz0;
  logic [OBJ_W-1:0]  amask;
  logic [OBJ_W-1:0]  sz1;
  logic [SLAB_W-1:0] raw_slab;

  always_comb begin
    sz0   = ({1'b0, object_size} < FLOOR_SZ) ? FLOOR_SZ : {1'b0, object_size};
    amask = (OBJ_W'(1) << align_log2) - OBJ_W'(1);
    sz1   = (sz0 + amask) & ~amask;
    obj_bytes = (sz1 > HALF_PAGE) ? ((sz1 + PMASK_O) & ~PMASK_O) : sz1;
    raw_slab  = SLAB_W'(obj_bytes) << SLOT_W;
    slab_bytes = (raw_slab + PMASK_S) & ~PMASK_S;
  end

endmodule

// ----- design/slab_object_allocator_top.sv -----
`timescale 1ns / 1ps
// Top level of the slab object allocator: slab table, scan and arithmetic sequencer.
// Depends on soa_pkg and soa_size.
//
// Usage:
//   Command channel: drive in_data and raise start; the item is taken at a
//   clock edge where start is high and busy is low. busy stays high until the
//   result has been shown.
//   Result channel: out_valid is high for exactly one cycle with out_data;
//   the receiver must take it then, it cannot stall the block.
//   Configuration: cfg_valid/cfg_ready write cfg_wdata to register cfg_index
//   (0 object_size, 1 align_log2, 2 region_base); cfg_ready is always high.
//   Write registers only while busy is low.
// Sequence: after the accepting edge, the block scans every slab and then decides.
//   An allocate then forms region base + slab index * slab size + slot * object
//   size with the shared adder; a free subtracts the object size from the offset
//   slot by slot to find the slot; out of memory and a free that hits no slab skip
//   this. The strobe follows, busy then drops and the next item can be taken.
//   Items are handled one at a time.
// Reset: synchronous rst_n clears all slabs to unallocated, maps and stamps to
//   zero and the registers to their defaults; no clearing pass is needed.
module slab_object_allocator_top import soa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  soa_in_t     in_data,
  output logic        out_valid,
  output soa_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_ADDS   = 3'd3;
  localparam logic [2:0] S_ADDB   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [SLAB_IDX_W-1:0] LAST_IDX = SLAB_IDX_W'(MAX_SLABS - 1);
  localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(SLOTS - 1);

  logic [16:0] object_size_r;
  logic [3:0]  align_log2_r;
  logic [31:0] region_base_r;

  logic [31:0] map_r   [MAX_SLABS];
  logic [1:0]  tag_r   [MAX_SLABS];
  logic [31:0] stamp_r [MAX_SLABS];
  logic [31:0] stamp_cnt_r, stamp_cnt_nxt;

  logic [2:0]            state_r, state_nxt;
  logic                  func_r, func_nxt;
  logic [31:0]           addr_r, addr_nxt;
  logic [SLAB_IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]           start_r, start_nxt;

  logic                  bp_vld_r, bp_vld_nxt, be_vld_r, be_vld_nxt, un_vld_r, un_vld_nxt;
  logic [SLAB_IDX_W-1:0] bp_idx_r, bp_idx_nxt, be_idx_r, be_idx_nxt, un_idx_r, un_idx_nxt;
  logic [31:0]           bp_stamp_r, bp_stamp_nxt, be_stamp_r, be_stamp_nxt;
  logic [31:0]           bp_map_r, bp_map_nxt, be_map_r, be_map_nxt;
  logic                  fh_vld_r, fh_vld_nxt, ph_vld_r, ph_vld_nxt;
  logic [SLAB_IDX_W-1:0] fh_idx_r, fh_idx_nxt, ph_idx_r, ph_idx_nxt;
  logic [31:0]           fh_map_r, fh_map_nxt, ph_map_r, ph_map_nxt;
  logic [SLAB_W-1:0]     fh_off_r, fh_off_nxt, ph_off_r, ph_off_nxt;

  logic [SLAB_IDX_W-1:0] sel_idx_r, sel_idx_nxt;
  logic [31:0]           sel_map_r, sel_map_nxt;
  logic [1:0]            sel_tag_r, sel_tag_nxt;
  logic [SLOT_W-1:0]     bit_r, bit_nxt;
  logic [SLOT_W-1:0]     cnt_r, cnt_nxt;
  logic [31:0]           acc_r, acc_nxt;
  logic [SLAB_W-1:0]     rem_r, rem_nxt;
  logic [31:0]           res_addr_r, res_addr_nxt;
  logic [1:0]            res_status_r, res_status_nxt;

  logic [OBJ_W-1:0]  obj_bytes;
  logic [SLAB_W-1:0] slab_bytes;

  // table write port
  logic                  wr_en;
  logic [SLAB_IDX_W-1:0] wr_idx;
  logic [31:0]           wr_map;
  logic [1:0]            wr_tag;
  logic [31:0]           wr_stamp;

  logic [31:0]       scan_off;
  logic              scan_in;
  logic [31:0]       add_opnd;
  logic [31:0]       add_sum;
  logic [31:0]       pick_map;
  logic [1:0]        pick_was;
  logic [SLOT_W-1:0] free_bit;
  logic              free_found;
  logic [31:0]       new_map;
  logic [31:0]       cnt_base;

  soa_size u_size (
    .object_size (object_size_r),
    .align_log2  (align_log2_r),
    .obj_bytes   (obj_bytes),
    .slab_bytes  (slab_bytes)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data.address_res = res_addr_r;
  assign out_data.status      = res_status_r;

  // scan-side address match and the shared accumulate adder
  assign scan_off = addr_r - start_r;
  assign scan_in  = (scan_off < {8'd0, slab_bytes});
  assign add_opnd = (state_r == S_ADDS) ? {8'd0, slab_bytes} : {14'd0, obj_bytes};
  assign add_sum  = acc_r + add_opnd;

  always_comb begin
    pick_map = map_r[0];
    pick_was = TAG_EMPTY;
    if (bp_vld_r) begin
      pick_map = bp_map_r;
      pick_was = TAG_PARTIAL;
    end else if (be_vld_r) begin
      pick_map = be_map_r;
    end else begin
      pick_map = 32'd0;
    end
  end

  // lowest clear slot in 0..30, else the last slot
  always_comb begin
    free_bit   = LAST_SLOT;
    free_found = 1'b0;
    for (int b = 0; b < SLOTS - 1; b++) begin
      if (!free_found && !pick_map[b]) begin
        free_bit   = SLOT_W'(b);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    addr_nxt       = addr_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    bp_vld_nxt     = bp_vld_r;   bp_idx_nxt = bp_idx_r;
    bp_stamp_nxt   = bp_stamp_r; bp_map_nxt = bp_map_r;
    be_vld_nxt     = be_vld_r;   be_idx_nxt = be_idx_r;
    be_stamp_nxt   = be_stamp_r; be_map_nxt = be_map_r;
    un_vld_nxt     = un_vld_r;   un_idx_nxt = un_idx_r;
    fh_vld_nxt     = fh_vld_r;   fh_idx_nxt = fh_idx_r;
    fh_map_nxt     = fh_map_r;   fh_off_nxt = fh_off_r;
    ph_vld_nxt     = ph_vld_r;   ph_idx_nxt = ph_idx_r;
    ph_map_nxt     = ph_map_r;   ph_off_nxt = ph_off_r;
    sel_idx_nxt    = sel_idx_r;
    sel_map_nxt    = sel_map_r;
    sel_tag_nxt    = sel_tag_r;
    bit_nxt        = bit_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    stamp_cnt_nxt  = stamp_cnt_r;
    wr_en    = 1'b0;
    wr_idx   = sel_idx_r;
    wr_map   = 32'd0;
    wr_tag   = TAG_UNALLOC;
    wr_stamp = 32'd0;
    new_map  = 32'd0;
    cnt_base = stamp_cnt_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt   = in_data.func;
          addr_nxt   = in_data.address;
          idx_nxt    = '0;
          start_nxt  = region_base_r;
          bp_vld_nxt = 1'b0;
          be_vld_nxt = 1'b0;
          un_vld_nxt = 1'b0;
          fh_vld_nxt = 1'b0;
          ph_vld_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        // ascending scan: strict compare keeps the lower index on a stamp tie
        if (tag_r[idx_r] == TAG_PARTIAL && (!bp_vld_r || stamp_r[idx_r] > bp_stamp_r)) begin
          bp_vld_nxt = 1'b1; bp_idx_nxt = idx_r;
          bp_stamp_nxt = stamp_r[idx_r]; bp_map_nxt = map_r[idx_r];
        end
        if (tag_r[idx_r] == TAG_EMPTY && (!be_vld_r || stamp_r[idx_r] > be_stamp_r)) begin
          be_vld_nxt = 1'b1; be_idx_nxt = idx_r;
          be_stamp_nxt = stamp_r[idx_r]; be_map_nxt = map_r[idx_r];
        end
        if (tag_r[idx_r] == TAG_UNALLOC && !un_vld_r) begin
          un_vld_nxt = 1'b1; un_idx_nxt = idx_r;
        end
        if (tag_r[idx_r] == TAG_FULL && scan_in && !fh_vld_r) begin
          fh_vld_nxt = 1'b1; fh_idx_nxt = idx_r;
          fh_map_nxt = map_r[idx_r]; fh_off_nxt = scan_off[SLAB_W-1:0];
        end
        if (tag_r[idx_r] == TAG_PARTIAL && scan_in && !ph_vld_r) begin
          ph_vld_nxt = 1'b1; ph_idx_nxt = idx_r;
          ph_map_nxt = map_r[idx_r]; ph_off_nxt = scan_off[SLAB_W-1:0];
        end
        start_nxt = start_r + {8'd0, slab_bytes};
        idx_nxt   = idx_r + SLAB_IDX_W'(1);
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_addr_nxt = 32'd0;
        if (func_r == FN_ALLOC) begin
          if (!bp_vld_r && !be_vld_r && !un_vld_r) begin
            res_status_nxt = ST_OOM;
            state_nxt      = S_OUT;
          end else begin
            sel_idx_nxt = bp_vld_r ? bp_idx_r : (be_vld_r ? be_idx_r : un_idx_r);
            wr_idx      = sel_idx_nxt;
            new_map     = pick_map | (32'd1 << free_bit);
            // a fresh slab goes on the empty list first
            cnt_base    = (!bp_vld_r && !be_vld_r) ? stamp_cnt_r + 32'd1 : stamp_cnt_r;
            wr_en       = 1'b1;
            wr_map      = new_map;
            wr_tag      = bp_vld_r ? TAG_PARTIAL : TAG_EMPTY;
            wr_stamp    = bp_vld_r ? bp_stamp_r : (be_vld_r ? be_stamp_r : stamp_cnt_r);
            stamp_cnt_nxt = cnt_base;
            if (new_map == '1) begin
              wr_tag = TAG_FULL; wr_stamp = cnt_base; stamp_cnt_nxt = cnt_base + 32'd1;
            end else if (pick_was == TAG_EMPTY) begin
              wr_tag = TAG_PARTIAL; wr_stamp = cnt_base; stamp_cnt_nxt = cnt_base + 32'd1;
            end
            acc_nxt        = region_base_r;
            cnt_nxt        = SLOT_W'(sel_idx_nxt);
            bit_nxt        = free_bit;
            res_status_nxt = ST_OK;
            state_nxt      = S_ADDS;
          end
        end else begin
          if (fh_vld_r) begin
            sel_idx_nxt = fh_idx_r; sel_map_nxt = fh_map_r;
            sel_tag_nxt = TAG_FULL; rem_nxt = fh_off_r;
            cnt_nxt = '0; state_nxt = S_DIV;
          end else if (ph_vld_r) begin
            sel_idx_nxt = ph_idx_r; sel_map_nxt = ph_map_r;
            sel_tag_nxt = TAG_PARTIAL; rem_nxt = ph_off_r;
            cnt_nxt = '0; state_nxt = S_DIV;
          end else begin
            res_status_nxt = ST_BAD_FREE;
            state_nxt      = S_OUT;
          end
        end
      end

      S_ADDS: begin
        if (cnt_r == '0) begin
          cnt_nxt   = bit_r;
          state_nxt = S_ADDB;
        end else begin
          acc_nxt = add_sum;
          cnt_nxt = cnt_r - SLOT_W'(1);
        end
      end

      S_ADDB: begin
        if (cnt_r == '0) begin
          res_addr_nxt = acc_r;
          state_nxt    = S_OUT;
        end else begin
          acc_nxt = add_sum;
          cnt_nxt = cnt_r - SLOT_W'(1);
        end
      end

      S_DIV: begin
        if (rem_r < SLAB_W'(obj_bytes)) begin
          new_map  = sel_map_r & ~(32'd1 << cnt_r);
          wr_en    = 1'b1;
          wr_map   = new_map;
          wr_tag   = sel_tag_r;
          wr_stamp = stamp_r[sel_idx_r];
          if (new_map == 32'd0) begin
            wr_tag = TAG_EMPTY; wr_stamp = stamp_cnt_r; stamp_cnt_nxt = stamp_cnt_r + 32'd1;
          end else if (sel_tag_r == TAG_FULL) begin
            wr_tag = TAG_PARTIAL; wr_stamp = stamp_cnt_r; stamp_cnt_nxt = stamp_cnt_r + 32'd1;
          end
          res_status_nxt = ST_OK;
          state_nxt      = S_OUT;
        end else if (cnt_r == LAST_SLOT) begin
          // quotient reaches the slot count: past the last slot
          res_status_nxt = ST_BAD_FREE;
          state_nxt      = S_OUT;
        end else begin
          rem_nxt = rem_r - SLAB_W'(obj_bytes);
          cnt_nxt = cnt_r + SLOT_W'(1);
        end
      end

      S_OUT: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      object_size_r <= 17'd64;
      align_log2_r  <= 4'd3;
      region_base_r <= 32'd0;
      stamp_cnt_r   <= 32'd0;
      for (int s = 0; s < MAX_SLABS; s++) begin
        map_r[s]   <= 32'd0;
        tag_r[s]   <= TAG_UNALLOC;
        stamp_r[s] <= 32'd0;
      end
    end else begin
      state_r     <= state_nxt;
      stamp_cnt_r <= stamp_cnt_nxt;
      if (wr_en) begin
        map_r[wr_idx]   <= wr_map;
        tag_r[wr_idx]   <= wr_tag;
        stamp_r[wr_idx] <= wr_stamp;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OBJECT_SIZE: object_size_r <= cfg_wdata[16:0];
          REG_ALIGN_LOG2:  align_log2_r  <= cfg_wdata[3:0];
          REG_REGION_BASE: region_base_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    addr_r       <= addr_nxt;
    idx_r        <= idx_nxt;
    start_r      <= start_nxt;
    bp_vld_r     <= bp_vld_nxt;   bp_idx_r <= bp_idx_nxt;
    bp_stamp_r   <= bp_stamp_nxt; bp_map_r <= bp_map_nxt;
    be_vld_r     <= be_vld_nxt;   be_idx_r <= be_idx_nxt;
    be_stamp_r   <= be_stamp_nxt; be_map_r <= be_map_nxt;
    un_vld_r     <= un_vld_nxt;   un_idx_r <= un_idx_nxt;
    fh_vld_r     <= fh_vld_nxt;   fh_idx_r <= fh_idx_nxt;
    fh_map_r     <= fh_map_nxt;   fh_off_r <= fh_off_nxt;
    ph_vld_r     <= ph_vld_nxt;   ph_idx_r <= ph_idx_nxt;
    ph_map_r     <= ph_map_nxt;   ph_off_r <= ph_off_nxt;
    sel_idx_r    <= sel_idx_nxt;
    sel_map_r    <= sel_map_nxt;
    sel_tag_r    <= sel_tag_nxt;
    bit_r        <= bit_nxt;
    cnt_r        <= cnt_nxt;
    acc_r        <= acc_nxt;
    rem_r        <= rem_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
  end

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_OOM ||
                   out_data.status == ST_BAD_FREE)) else $error("bad status code");

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(stamp_cnt_r) |-> ($past(state_r) == S_DECIDE || $past(state_r) == S_DIV))
    else $error("stamp counter moved outside a table update");
`endif

endmodule
